// ===== rtl/ldim_pkg.sv =====
// shared types and constants for the led fade pwm dimmer
// no dependencies; imported by the interfaces and the top level
package ldim_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 16;
    localparam int LEDS_W    = 4;
    localparam int FSEC_W    = 8;
    localparam int PCT_W     = 8;
    localparam int LVL_W     = 7;
    localparam int BRIGHT_W  = 23;
    localparam int STEP_W    = 24;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int MAX_LEDS  = 8;

    localparam logic [LVL_W-1:0]    PCT_MAX    = 7'd100;
    localparam logic [BRIGHT_W-1:0] FULL_SCALE = 23'(100 << FRAC_BITS);
    localparam int                  SNAP_LSB   = 655;
    localparam int                  ROUND_LSB  = 6554;
    localparam logic [LEDS_W-1:0]   LED_LIM    =
        LEDS_W'((MAX_LEDS < MASK_W) ? MAX_LEDS : MASK_W);

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0]  PERIOD_RST = 16'd100;
    localparam logic [LEDS_W-1:0] LEDS_RST   = 4'd1;
    localparam logic              FADE_RST   = 1'b1;
    localparam logic [FSEC_W-1:0] FSEC_RST   = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD   = 2'd0,
        CFG_LEDS     = 2'd1,
        CFG_FADE_EN  = 2'd2,
        CFG_FADE_SEC = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_TICK = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

// ===== rtl/ldim_if.sv =====
// valid/ready channel interfaces: item input, result output, register writes
// depends on ldim_pkg for field widths
interface ldim_in_if;
    import ldim_pkg::*;
    logic             valid;
    logic             ready;
    logic             func;
    logic [PCT_W-1:0] target_percent;
    modport source (output valid, func, target_percent, input ready);
    modport sink (input valid, func, target_percent, output ready);
endinterface

interface ldim_out_if;
    import ldim_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] lit_mask;
    logic [MASK_W-1:0] pin_levels;
    logic [LVL_W-1:0]  brightness_level;
    modport source (output valid, lit_mask, pin_levels, brightness_level, input ready);
    modport sink (input valid, lit_mask, pin_levels, brightness_level, output ready);
endinterface

interface ldim_cfg_if;
    import ldim_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ldim_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// standalone; used by led_fade_pwm_dimmer for the fade step
module ldim_div #(
    parameter int N_W = 23,
    parameter int D_W = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);
    localparam int C_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [D_W-1:0] r_rem, n_rem;
    logic [N_W-1:0] r_quo, n_quo;
    logic [D_W-1:0] r_den;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    always_comb begin
        trial = {r_rem, r_quo[N_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[D_W-1:0] : trial[D_W-1:0];
        n_quo = {r_quo[N_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/led_fade_pwm_dimmer.sv =====
// led fade pwm dimmer: a tick word runs S_TICK then S_FIN, a set word S_FIN
// alone without fade, or S_PREP, S_DIV (23 iterations of the restoring
// divider, one quotient bit a cycle) and S_FIN with fade; S_FIN loads the
// output register. one word at a time: a new word is taken once the previous
// one has left S_FIN, even while its result still waits in the output register.
// synchronous active-low reset loads register defaults and clears control state.
module led_fade_pwm_dimmer #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldim_in_if.sink    i_item,
    ldim_cfg_if.sink   i_cfg,
    ldim_out_if.source o_res
);
    import ldim_pkg::*;

    localparam int DIV_W = $clog2((2 ** FSEC_W - 1) * TICKS_PER_SECOND + 1);

    // configuration
    logic [CNT_W-1:0]  r_period;
    logic [LEDS_W-1:0] r_leds;
    logic              r_fade_en;
    logic [FSEC_W-1:0] r_fsec;

    // dimmer state
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_pcnt, n_pcnt;
    logic [BRIGHT_W-1:0]       r_bright, n_bright;
    logic signed [STEP_W-1:0]  r_step, n_step;
    logic [LVL_W-1:0]          r_target, n_target;
    logic [MASK_W-1:0]         r_mask, n_mask;
    logic                      r_is_tick, n_is_tick;
    logic                      r_neg, n_neg;
    logic                      r_nz, n_nz;

    // output register
    logic                      r_ovalid, n_ovalid;
    logic [MASK_W-1:0]         r_omask, n_omask;
    logic [LVL_W-1:0]          r_olevel, n_olevel;

    // datapath
    logic [LVL_W-1:0]          pct_clamp;
    logic [BRIGHT_W-1:0]       tgt_b;
    logic signed [STEP_W-1:0]  diff;
    logic [BRIGHT_W-1:0]       mag;
    logic [DIV_W-1:0]          den;
    logic                      div_start;
    logic                      div_done;
    logic [BRIGHT_W-1:0]       div_quo;
    logic [BRIGHT_W-1:0]       quo_fix;
    logic [CNT_W:0]            pcnt_inc;
    logic signed [25:0]        nb;
    logic signed [25:0]        tgt_s;
    logic signed [25:0]        dnb;
    logic signed [25:0]        sel;
    logic                      passed;
    logic                      snap;
    logic [BRIGHT_W:0]         lvl_sum;
    logic [LVL_W-1:0]          lvl;
    logic                      lvl_gt;
    logic [LEDS_W-1:0]         lim;
    logic [MASK_W-1:0]         lit;

    ldim_div #(
        .N_W (BRIGHT_W),
        .D_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration writes, taken on any cycle
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_leds    <= LEDS_RST;
            r_fade_en <= FADE_RST;
            r_fsec    <= FSEC_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PERIOD:   r_period  <= i_cfg.data[CNT_W-1:0];
                CFG_LEDS:     r_leds    <= i_cfg.data[LEDS_W-1:0];
                CFG_FADE_EN:  r_fade_en <= i_cfg.data[0];
                CFG_FADE_SEC: r_fsec    <= i_cfg.data[FSEC_W-1:0];
                default:      r_period  <= r_period;
            endcase
        end
    end

    always_comb begin
        pct_clamp = (i_item.target_percent > {1'b0, PCT_MAX})
                  ? PCT_MAX : i_item.target_percent[LVL_W-1:0];
        tgt_b     = {r_target, {FRAC_BITS{1'b0}}};

        // distance and divisor for the fade step
        diff = $signed({1'b0, tgt_b}) - $signed({1'b0, r_bright});
        mag  = diff[STEP_W-1] ? BRIGHT_W'(-diff) : diff[BRIGHT_W-1:0];
        den  = DIV_W'(r_fsec) * DIV_W'(TICKS_PER_SECOND);

        // a zero quotient over a non-zero distance still moves one lsb
        quo_fix = (div_quo == '0 && r_nz) ? BRIGHT_W'(1) : div_quo;

        // tick: counter wrap and one fade step with snap and clamp
        pcnt_inc = {1'b0, r_pcnt} + 1'b1;
        nb       = $signed({3'b0, r_bright}) + 26'(r_step);
        tgt_s    = $signed({3'b0, tgt_b});
        dnb      = nb - tgt_s;
        passed   = (!r_step[STEP_W-1] && r_step != '0 && nb > tgt_s)
                || (r_step[STEP_W-1] && nb < tgt_s);
        snap     = (dnb < 26'sd656) && (dnb > -26'sd656);
        sel      = (passed || snap) ? tgt_s : nb;
        if (sel < 26'sd0) begin
            sel = '0;
        end else if (sel > $signed({3'b0, FULL_SCALE})) begin
            sel = $signed({3'b0, FULL_SCALE});
        end

        // duty level and led mask
        lvl_sum = {1'b0, r_bright} + (BRIGHT_W + 1)'(ROUND_LSB);
        lvl     = lvl_sum[FRAC_BITS +: LVL_W];
        lvl_gt  = {{(CNT_W - LVL_W){1'b0}}, lvl} > r_pcnt;
        lim     = (r_leds > LED_LIM) ? LED_LIM : r_leds;
        for (int i = 0; i < MASK_W; i++) begin
            lit[i] = lvl_gt && (LEDS_W'(i) < lim);
        end
    end

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_pcnt    = r_pcnt;
        n_bright  = r_bright;
        n_step    = r_step;
        n_target  = r_target;
        n_mask    = r_mask;
        n_is_tick = r_is_tick;
        n_neg     = r_neg;
        n_nz      = r_nz;
        n_ovalid  = r_ovalid;
        n_omask   = r_omask;
        n_olevel  = r_olevel;
        div_start = 1'b0;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_is_tick = !i_item.func;
                    if (i_item.func) begin
                        n_target = pct_clamp;
                        if (r_fade_en && r_fsec != '0) begin
                            n_state = S_PREP;
                        end else begin
                            n_bright = {pct_clamp, {FRAC_BITS{1'b0}}};
                            n_state  = S_FIN;
                        end
                    end else begin
                        n_state = S_TICK;
                    end
                end
            end
            S_PREP: begin
                div_start = 1'b1;
                n_neg     = diff[STEP_W-1];
                n_nz      = (mag != '0);
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_step  = r_neg ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix});
                    n_state = S_FIN;
                end
            end
            S_TICK: begin
                n_pcnt = (pcnt_inc >= {1'b0, r_period}) ? '0 : pcnt_inc[CNT_W-1:0];
                if (r_fade_en && r_bright != tgt_b) begin
                    n_bright = sel[BRIGHT_W-1:0];
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_omask  = r_is_tick ? lit : r_mask;
                    n_olevel = lvl;
                    if (r_is_tick) begin
                        n_mask = lit;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pcnt    <= '0;
            r_bright  <= '0;
            r_step    <= '0;
            r_target  <= '0;
            r_mask    <= '0;
            r_is_tick <= 1'b0;
            r_neg     <= 1'b0;
            r_nz      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pcnt    <= n_pcnt;
            r_bright  <= n_bright;
            r_step    <= n_step;
            r_target  <= n_target;
            r_mask    <= n_mask;
            r_is_tick <= n_is_tick;
            r_neg     <= n_neg;
            r_nz      <= n_nz;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_omask  <= n_omask;
        r_olevel <= n_olevel;
    end

    assign o_res.valid            = r_ovalid;
    assign o_res.lit_mask         = r_omask;
    assign o_res.pin_levels       = ~r_omask;
    assign o_res.brightness_level = r_olevel;

    a_bright_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bright <= FULL_SCALE)
        else $error("brightness above full scale");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_mask_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != $past(r_mask)) |-> $past(r_state == S_FIN && r_is_tick))
        else $error("pin mask changed outside a tick");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_olevel <= PCT_MAX)
        else $error("duty level above 100");

endmodule

// ===== test/tb.sv =====
// testbench for the led fade pwm dimmer: directed and random words checked
// against a local duty predictor, with random idling on item and result channels
// depends on ldim_pkg, the channel interfaces in ldim_if.sv and the dimmer top level
module tb;
    import ldim_pkg::*;

    localparam int   TICKS_PER_SEC = 1000;
    localparam int   SETTLE_CYCLES = 32;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam logic FN_TICK       = 1'b0;
    localparam logic FN_SET        = 1'b1;

    typedef struct packed {
        logic [MASK_W-1:0] lit;
        logic [MASK_W-1:0] pins;
        logic [LVL_W-1:0]  level;
    } t_duty_word;

    logic i_clk;
    logic i_rst_n;

    ldim_in_if  item_ch();
    ldim_cfg_if cfg_ch();
    ldim_out_if res_ch();

    led_fade_pwm_dimmer #(.TICKS_PER_SECOND(TICKS_PER_SEC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // predictor copy of the registers and the dimmer state
    logic [CNT_W-1:0]         reg_period;
    logic [LEDS_W-1:0]        reg_leds;
    logic                     reg_fade;
    logic [FSEC_W-1:0]        reg_fsec;
    logic [CNT_W-1:0]         pwm_cnt;
    logic [BRIGHT_W-1:0]      duty_q16;
    logic signed [STEP_W-1:0] ramp_step;
    logic [LVL_W-1:0]         duty_target;
    logic [MASK_W-1:0]        pin_mask;

    t_duty_word pending_duty[$];
    int         errors;
    int         tx_gap_max;
    int         rx_stall_max;
    int         rx_hold_req;
    longint     cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[led_fade_pwm_dimmer] ERROR");
        $finish;
    end

    function automatic logic [LVL_W-1:0] duty_level();
        return LVL_W'((longint'(duty_q16) + ROUND_LSB) >> FRAC_BITS);
    endfunction

    function automatic t_duty_word report_duty();
        t_duty_word w;
        w.lit   = pin_mask;
        w.pins  = ~pin_mask;
        w.level = duty_level();
        return w;
    endfunction

    function automatic t_duty_word advance_tick();
        longint            nxt;
        longint            tgt;
        longint            nb;
        longint            d;
        logic              passed;
        logic [LEDS_W-1:0] lim;
        nxt = longint'(pwm_cnt) + 1;
        pwm_cnt = (nxt >= longint'(reg_period)) ? '0 : CNT_W'(nxt);
        tgt = longint'(duty_target) << FRAC_BITS;
        if (reg_fade && longint'(duty_q16) != tgt) begin
            nb = longint'(duty_q16) + longint'(ramp_step);
            d = nb - tgt;
            passed = (ramp_step > 0 && nb > tgt) || (ramp_step < 0 && nb < tgt);
            // land on the target when close enough or when the step overshot
            if (passed || (d <= SNAP_LSB && d >= -SNAP_LSB))
                nb = tgt;
            if (nb < 0)
                nb = 0;
            if (nb > longint'(FULL_SCALE))
                nb = FULL_SCALE;
            duty_q16 = BRIGHT_W'(nb);
        end
        lim = (reg_leds > LED_LIM) ? LED_LIM : reg_leds;
        pin_mask = (duty_level() > pwm_cnt) ? MASK_W'((1 << lim) - 1) : '0;
        return report_duty();
    endfunction

    function automatic t_duty_word apply_target(logic [PCT_W-1:0] pct);
        longint tgt;
        longint diff;
        longint span;
        longint mag;
        longint q;
        duty_target = (pct > PCT_MAX) ? PCT_MAX : LVL_W'(pct);
        tgt = longint'(duty_target) << FRAC_BITS;
        if (reg_fade && reg_fsec != 0) begin
            diff = tgt - longint'(duty_q16);
            span = longint'(reg_fsec) * TICKS_PER_SEC;
            mag = (diff < 0) ? -diff : diff;
            q = mag / span;
            // a fade must always end, so no zero step over a nonzero distance
            if (q == 0 && mag != 0)
                q = 1;
            ramp_step = STEP_W'((diff < 0) ? -q : q);
        end else begin
            duty_q16 = BRIGHT_W'(tgt);
        end
        return report_duty();
    endfunction

    task automatic send_word(input logic fn, input logic [PCT_W-1:0] pct);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap != 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid          = 1'b1;
        item_ch.func           = fn;
        item_ch.target_percent = pct;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (fn == FN_SET)
            pending_duty.push_back(apply_target(pct));
        else
            pending_duty.push_back(advance_tick());
    endtask

    task automatic send_random();
        if ($urandom_range(0, 3) == 0)
            send_word(FN_SET, PCT_W'($urandom_range(0, 255)));
        else
            send_word(FN_TICK, PCT_W'($urandom_range(0, 255)));
    endtask

    // stop offering words and let every outstanding result come back
    task automatic settle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (pending_duty.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        settle();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = CFG_DAT_W'(val);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_PERIOD:   reg_period = CNT_W'(val);
            CFG_LEDS:     reg_leds   = LEDS_W'(val);
            CFG_FADE_EN:  reg_fade   = val[0];
            CFG_FADE_SEC: reg_fsec   = FSEC_W'(val);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // result side: check each word, then draw the stall before the next one
    initial begin
        int         stall;
        int         hold;
        t_duty_word want;
        res_ch.ready = 1'b0;
        stall = 0;
        hold  = 0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                if (pending_duty.size() == 0) begin
                    $error("result word with nothing pending");
                    errors++;
                end else begin
                    want = pending_duty.pop_front();
                    if (res_ch.lit_mask !== want.lit) begin
                        $error("lit_mask: expected %0h, got %0h", want.lit, res_ch.lit_mask);
                        errors++;
                    end
                    if (res_ch.pin_levels !== want.pins) begin
                        $error("pin_levels: expected %0h, got %0h",
                               want.pins, res_ch.pin_levels);
                        errors++;
                    end
                    if (res_ch.brightness_level !== want.level) begin
                        $error("brightness_level: expected %0d, got %0d",
                               want.level, res_ch.brightness_level);
                        errors++;
                    end
                end
                stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
            end
            if (rx_hold_req != 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end
            @(negedge i_clk);
            if (hold != 0) begin
                res_ch.ready = 1'b0;
                hold--;
            end else if (stall != 0) begin
                res_ch.ready = 1'b0;
                stall--;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    task automatic test_reset_defaults();
        send_word(FN_TICK, 8'd0);
        send_word(FN_SET, 8'd255);
        send_word(FN_TICK, 8'd0);
        send_word(FN_SET, 8'd0);
        send_word(FN_TICK, 8'd255);
        send_word(FN_SET, 8'd101);
        send_word(FN_SET, 8'd100);
    endtask

    task automatic test_jump_and_leds();
        write_reg(CFG_FADE_EN, 0);
        write_reg(CFG_LEDS, 15);
        send_word(FN_SET, 8'd100);
        send_word(FN_TICK, 8'd0);
        write_reg(CFG_LEDS, 0);
        send_word(FN_TICK, 8'd0);
        write_reg(CFG_LEDS, 8);
        send_word(FN_TICK, 8'd0);
        send_word(FN_SET, 8'd0);
        send_word(FN_TICK, 8'd0);
    endtask

    task automatic test_period_edges();
        send_word(FN_SET, 8'd100);
        write_reg(CFG_PERIOD, 0);
        send_word(FN_TICK, 8'd0);
        send_word(FN_TICK, 8'd0);
        write_reg(CFG_PERIOD, 65535);
        repeat (3) send_word(FN_TICK, 8'd0);
        // counter now sits above the new period and must wrap at once
        write_reg(CFG_PERIOD, 2);
        send_word(FN_TICK, 8'd0);
    endtask

    task automatic test_fade_details();
        send_word(FN_SET, 8'd0);
        write_reg(CFG_FADE_EN, 1);
        write_reg(CFG_FADE_SEC, 1);
        send_word(FN_SET, 8'd1);
        send_word(FN_TICK, 8'd0);
        // tiny distance: step floors to one lsb, then snaps home
        send_word(FN_SET, 8'd0);
        send_word(FN_TICK, 8'd0);
        write_reg(CFG_FADE_SEC, 255);
        send_word(FN_SET, 8'd1);
        send_word(FN_TICK, 8'd0);
        send_word(FN_SET, 8'd50);
        send_word(FN_TICK, 8'd0);
        // ramp frozen while fading is off
        write_reg(CFG_FADE_EN, 0);
        send_word(FN_TICK, 8'd0);
        write_reg(CFG_FADE_SEC, 0);
        write_reg(CFG_FADE_EN, 1);
        send_word(FN_SET, 8'd30);
        send_word(FN_TICK, 8'd0);
    endtask

    // 0 to 7 percent over one second leaves a residue wider than the snap
    // window, so the ramp takes one extra step and snaps onto the target
    task automatic test_full_ramp();
        write_reg(CFG_FADE_EN, 0);
        send_word(FN_SET, 8'd0);
        write_reg(CFG_FADE_EN, 1);
        write_reg(CFG_FADE_SEC, 1);
        write_reg(CFG_PERIOD, 12);
        write_reg(CFG_LEDS, 3);
        send_word(FN_SET, 8'd7);
        for (int n = 0; n < 1005; n++) begin
            if (n % 100 == 0) begin
                tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 16;
                rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            end
            send_word(FN_TICK, PCT_W'($urandom_range(0, 255)));
        end
        tx_gap_max   = 16;
        rx_stall_max = 16;
    endtask

    task automatic test_output_stall();
        tx_gap_max  = 0;
        rx_hold_req = 400;
        send_word(FN_SET, 8'd60);
        repeat (29) send_random();
        tx_gap_max = 16;
    endtask

    task automatic test_sender_pause();
        repeat (12) send_random();
        settle();
        repeat (12) send_random();
    endtask

    task automatic test_random_mix();
        int unsigned u;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_PERIOD, 0);
                write_reg(CFG_LEDS, 0);
                write_reg(CFG_FADE_EN, 0);
                write_reg(CFG_FADE_SEC, 0);
            end else if (ph == 1) begin
                write_reg(CFG_PERIOD, 65535);
                write_reg(CFG_LEDS, 15);
                write_reg(CFG_FADE_EN, 1);
                write_reg(CFG_FADE_SEC, 255);
            end else begin
                u = $urandom_range(0, 5);
                write_reg(CFG_PERIOD, (u == 0) ? 1 : (u == 1) ? 65535 : $urandom_range(2, 120));
                write_reg(CFG_LEDS, $urandom_range(0, 15));
                write_reg(CFG_FADE_EN, ($urandom_range(0, 3) != 0) ? 1 : 0);
                u = $urandom_range(0, 5);
                write_reg(CFG_FADE_SEC, (u == 0) ? 0 : (u == 1) ? 255 : $urandom_range(1, 3));
            end
            tx_gap_max   = (ph % 3 == 0) ? 0 : 16;
            rx_stall_max = (ph % 4 == 1) ? 0 : 16;
            repeat (40) send_random();
        end
        tx_gap_max   = 16;
        rx_stall_max = 16;
    endtask

    initial begin
        i_rst_n                = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.func           = FN_TICK;
        item_ch.target_percent = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_PERIOD;
        cfg_ch.data            = '0;
        errors       = 0;
        tx_gap_max   = 16;
        rx_stall_max = 16;
        rx_hold_req  = 0;
        reg_period   = PERIOD_RST;
        reg_leds     = LEDS_RST;
        reg_fade     = FADE_RST;
        reg_fsec     = FSEC_RST;
        pwm_cnt      = '0;
        duty_q16     = '0;
        ramp_step    = '0;
        duty_target  = '0;
        pin_mask     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_jump_and_leds();
        test_period_edges();
        test_fade_details();
        test_full_ramp();
        test_output_stall();
        test_sender_pause();
        test_random_mix();
        settle();

        if (errors == 0)
            $display("[led_fade_pwm_dimmer] OK");
        else
            $display("[led_fade_pwm_dimmer] ERROR");
        $finish;
    end

endmodule

// ===== led_fade_pwm_dimmer.f =====
rtl/ldim_pkg.sv
rtl/ldim_if.sv
rtl/ldim_div.sv
rtl/led_fade_pwm_dimmer.sv
test/tb.sv
